/* rtl/core/wavetable_lfo_interpolating_defines.svh */
// assertion macros shared by the wavetable lfo rtl
`ifndef WAVETABLE_LFO_INTERPOLATING_DEFINES_SVH
`define WAVETABLE_LFO_INTERPOLATING_DEFINES_SVH

// same-cycle implication
`define WTLFO_ASSERT_IMPL(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_n_s)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define WTLFO_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_n_s)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/core/wtlfo_pkg.sv */
// constants and register indexes of the wavetable lfo
package wtlfo_pkg;

	localparam int TABLE_SIZE_DEF = 1024;
	localparam int NUM_BANDS_DEF  = 32;
	localparam int PHASE_BITS_DEF = 24;

	localparam int STORE_DEPTH = 32768;
	localparam int ADDR_W      = 15;
	localparam int SAMPLE_W    = 16;
	localparam int STEP_W      = 24;
	localparam int LEVEL_W     = 16;
	localparam int BAND_W      = 5;
	localparam int CFG_W       = 24;
	localparam int CFG_IDX_W   = 3;

	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BAND         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MOD_ENABLE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WAVE_PRESENT = 3'd4;

	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 16'sh8000;

endpackage

/* rtl/core/wtlfo_ram.sv */
// generic single-write, registered-read ram
module wtlfo_ram #(
	parameter int WIDTH = wtlfo_pkg::SAMPLE_W,
	parameter int DEPTH = wtlfo_pkg::STORE_DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/wavetable_lfo_interpolating.sv */
// wavetable lfo with linear interpolation, level scaling and saturation
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   config   | cfg_we, cfg_index, cfg_data               | in
//   input    | in_valid, in_stall, action, table_address,| in
//            | table_data                                |
//   output   | out_valid, out_stall, sample_out          | out
//
// a write leaves the sequencer idle; a tick with a table present steps through index,
// bank base, read, interpolate, scale and done to the output register, a tick with no
// table goes to done; the steps share one multiplier and the single ram read port
// reset clears configuration, phase and control; the table store is not cleared
// in_stall is high from a tick transfer until its result enters the output register
// a finished result waits in the last step while the output register is full and stalled
`include "wavetable_lfo_interpolating_defines.svh"

module wavetable_lfo_interpolating #(
	parameter int TABLE_SIZE = wtlfo_pkg::TABLE_SIZE_DEF,
	parameter int NUM_BANDS  = wtlfo_pkg::NUM_BANDS_DEF,
	parameter int PHASE_BITS = wtlfo_pkg::PHASE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [wtlfo_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wtlfo_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  action,
	input  logic [wtlfo_pkg::ADDR_W-1:0]          table_address,
	input  logic signed [wtlfo_pkg::SAMPLE_W-1:0] table_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [wtlfo_pkg::SAMPLE_W-1:0] sample_out
);

	localparam int SW    = wtlfo_pkg::SAMPLE_W;
	localparam int AW    = wtlfo_pkg::ADDR_W;
	localparam int TS_W  = $clog2(TABLE_SIZE + 1);
	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int MA_W  = PHASE_BITS + 1;
	localparam int MB_W  = (TS_W + 1 > SW + 1) ? TS_W + 1 : SW + 1;
	localparam int P_W   = MA_W + MB_W;
	localparam int T_W   = PHASE_BITS + SW + 2;

	localparam logic signed [T_W-1:0] HALF_T = T_W'(64'd1 << (PHASE_BITS - 1));
	localparam logic signed [P_W-1:0] HALF_Y = P_W'(16384);
	localparam logic signed [P_W-1:0] SAT_HI = P_W'(32767);
	localparam logic signed [P_W-1:0] SAT_LO = P_W'(-32768);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_IDX    = 3'd1;
	localparam logic [2:0] S_BASE   = 3'd2;
	localparam logic [2:0] S_RDB    = 3'd3;
	localparam logic [2:0] S_INTERP = 3'd4;
	localparam logic [2:0] S_SCALE  = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0]                          state_q;
	logic [PHASE_BITS-1:0]               phase_q;
	logic [wtlfo_pkg::STEP_W-1:0]        step_q;
	logic [wtlfo_pkg::LEVEL_W-1:0]       level_q;
	logic [wtlfo_pkg::BAND_W-1:0]        band_q;
	logic                                mod_en_q;
	logic                                present_q;

	logic [IDX_W-1:0]                    ia_q;
	logic [PHASE_BITS-1:0]               frac_q;
	logic [AW-1:0]                       addr_b_q;
	logic signed [SW-1:0]                a_q;
	logic signed [SW-1:0]                q_q;
	logic signed [SW-1:0]                res_q;
	logic signed [SW-1:0]                out_q;
	logic                                out_valid_q;

	logic                                in_xfer;
	logic                                out_free;
	logic [wtlfo_pkg::BAND_W-1:0]        band_mod;
	logic signed [MA_W-1:0]              mul_a;
	logic signed [MB_W-1:0]              mul_b;
	logic signed [P_W-1:0]               mul_p;
	logic [IDX_W-1:0]                    ib;
	logic [AW-1:0]                       addr_a;
	logic [AW-1:0]                       addr_b;
	logic [AW-1:0]                       raddr;
	logic [SW-1:0]                       rd_data;
	logic signed [SW-1:0]                rd_sample;
	logic signed [SW:0]                  diff;
	logic signed [T_W-1:0]               t_full;
	logic signed [SW-1:0]                q_next;
	logic signed [P_W-1:0]               y_full;
	logic signed [SW-1:0]                y_sat;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign sample_out = out_q;

	// bank wrap
	always_comb begin
		band_mod = '0;
		for (int i = 0; i < 32; i++) begin
			if (band_q == wtlfo_pkg::BAND_W'(i)) begin
				band_mod = wtlfo_pkg::BAND_W'(i % NUM_BANDS);
			end
		end
	end

	assign rd_sample = $signed(rd_data);
	assign diff      = (SW + 1)'(rd_sample) - (SW + 1)'(a_q);

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			S_IDX: begin
				mul_a = {1'b0, phase_q};
				mul_b = MB_W'(TABLE_SIZE);
			end
			S_BASE: begin
				mul_a = MA_W'(band_mod);
				mul_b = MB_W'(TABLE_SIZE);
			end
			S_INTERP: begin
				mul_a = {1'b0, frac_q};
				mul_b = MB_W'(diff);
			end
			S_SCALE: begin
				mul_a = MA_W'(q_q);
				mul_b = MB_W'(level_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign ib     = (ia_q == IDX_W'(TABLE_SIZE - 1)) ? '0 : ia_q + 1'b1;
	assign addr_a = mul_p[AW-1:0] + AW'(ia_q);
	assign addr_b = mul_p[AW-1:0] + AW'(ib);
	assign raddr  = (state_q == S_BASE) ? addr_a : addr_b_q;

	assign t_full = (T_W'(a_q) <<< PHASE_BITS) + T_W'(mul_p) + HALF_T;
	assign q_next = SW'(t_full >>> PHASE_BITS);

	assign y_full = (mul_p + HALF_Y) >>> 15;
	always_comb begin
		if (y_full > SAT_HI) begin
			y_sat = wtlfo_pkg::SMP_MAX;
		end else if (y_full < SAT_LO) begin
			y_sat = wtlfo_pkg::SMP_MIN;
		end else begin
			y_sat = SW'(y_full);
		end
	end

	wtlfo_ram #(
		.WIDTH(SW),
		.DEPTH(wtlfo_pkg::STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (in_xfer && (action == wtlfo_pkg::ACT_WRITE)),
		.waddr(table_address),
		.wdata(table_data),
		.raddr(raddr),
		.rdata(rd_data)
	);

	// sequencer, phase and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			phase_q     <= '0;
			step_q      <= '0;
			level_q     <= '0;
			band_q      <= '0;
			mod_en_q    <= 1'b0;
			present_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					wtlfo_pkg::REG_PHASE_STEP:   step_q    <= cfg_data[wtlfo_pkg::STEP_W-1:0];
					wtlfo_pkg::REG_LEVEL:        level_q   <= cfg_data[wtlfo_pkg::LEVEL_W-1:0];
					wtlfo_pkg::REG_BAND:         band_q    <= cfg_data[wtlfo_pkg::BAND_W-1:0];
					wtlfo_pkg::REG_MOD_ENABLE:   mod_en_q  <= cfg_data[0];
					wtlfo_pkg::REG_WAVE_PRESENT: present_q <= cfg_data[0];
					default: ;
				endcase
			end

			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_xfer && (action == wtlfo_pkg::ACT_TICK)) begin
						state_q <= present_q ? S_IDX : S_DONE;
					end
				end
				S_IDX:    state_q <= S_BASE;
				S_BASE:   state_q <= S_RDB;
				S_RDB:    state_q <= S_INTERP;
				S_INTERP: state_q <= S_SCALE;
				S_SCALE:  state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (mod_en_q) begin
							phase_q <= phase_q + PHASE_BITS'(step_q);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: res_q <= '0;
			S_IDX: begin
				ia_q   <= mul_p[PHASE_BITS +: IDX_W];
				frac_q <= mul_p[PHASE_BITS-1:0];
			end
			S_BASE:   addr_b_q <= addr_b;
			S_RDB:    a_q      <= rd_sample;
			S_INTERP: q_q      <= q_next;
			S_SCALE:  res_q    <= y_sat;
			S_DONE: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	`WTLFO_ASSERT_NEXT(a_result_held, clk, arst_n, (state_q == S_DONE) && out_valid_q && out_stall, state_q == S_DONE)
	`WTLFO_ASSERT_NEXT(a_absent_short, clk, arst_n, in_xfer && (action == wtlfo_pkg::ACT_TICK) && !present_q, state_q == S_DONE)
	`WTLFO_ASSERT_NEXT(a_phase_only_done, clk, arst_n, state_q != S_DONE, $stable(phase_q))
	`WTLFO_ASSERT_NEXT(a_write_one_cycle, clk, arst_n, in_xfer && (action == wtlfo_pkg::ACT_WRITE), state_q == S_IDLE)

endmodule

/* tb/tb_top.sv */
// testbench for the wavetable lfo: directed table, random phases, sample prediction
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import wtlfo_pkg::*;

	localparam int TBL = TABLE_SIZE_DEF;
	localparam int NB = NUM_BANDS_DEF;
	localparam int PB = PHASE_BITS_DEF;
	localparam longint PHASE_MASK = (longint'(1) << PB) - 1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam int QUIET_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES = 200;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 42;

	typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_TICK} row_kind_e;
	typedef struct packed {
		row_kind_e          kind;
		logic [23:0]        sel;
		logic [23:0]        val;
		logic               typed;
		logic signed [15:0] want;
	} dir_row_t;

	localparam int DIR_ROWS = 36;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_W-1:0]           cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic                       action = ACT_TICK;
	logic [ADDR_W-1:0]          table_address = '0;
	logic signed [SAMPLE_W-1:0] table_data = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;

	// predictor state
	logic [STEP_W-1:0]   step_r = '0;
	logic [LEVEL_W-1:0]  level_r = '0;
	logic [BAND_W-1:0]   band_r = '0;
	logic                mod_r = 1'b0;
	logic                present_r = 1'b0;
	logic [PB-1:0]       phase_acc = '0;
	logic [SAMPLE_W-1:0] wave_mem [STORE_DEPTH];
	bit                  written [STORE_DEPTH];

	logic signed [SAMPLE_W-1:0] pending_samples [$];
	int errors = 0;
	int quiet_cycles = 0;
	int burst_left = 1;
	bit gaps_on = 1'b1;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_TICK, 24'd0, 24'd0, 1'b1, 16'sd0},
		'{ROW_CFG, 24'(REG_MOD_ENABLE), 24'd1, 1'b0, 16'sd0},
		'{ROW_CFG, 24'(REG_PHASE_STEP), 24'hFFFFFF, 1'b0, 16'sd0},
		'{ROW_TICK, 24'd0, 24'd0, 1'b1, 16'sd0},
		'{ROW_CFG, 24'(REG_PHASE_STEP), 24'd1, 1'b0, 16'sd0},
		'{ROW_TICK, 24'd0, 24'd0, 1'b1, 16'sd0},
		'{ROW_CFG, 24'(REG_MOD_ENABLE), 24'd0, 1'b0, 16'sd0},
		'{ROW_LOAD, 24'd3072, 24'h007FFF, 1'b0, 16'sd0},
		'{ROW_LOAD, 24'd3073, 24'h008000, 1'b0, 16'sd0},
		'{ROW_LOAD, 24'd5120, 24'h008000, 1'b0, 16'sd0},
		'{ROW_LOAD, 24'd32767, 24'h005A5A, 1'b0, 16'sd0},
		'{ROW_CFG, 24'(REG_BAND), 24'd3, 1'b0, 16'sd0},
		'{ROW_CFG, 24'(REG_LEVEL), 24'd32768, 1'b0, 16'sd0},
		'{ROW_CFG, 24'(REG_WAVE_PRESENT), 24'd1, 1'b0, 16'sd0},
		'{ROW_TICK, 24'd0, 24'd0, 1'b1, SMP_MAX},
		'{ROW_CFG, 24'(REG_LEVEL), 24'd65535, 1'b0, 16'sd0},
		'{ROW_TICK, 24'd0, 24'd0, 1'b1, SMP_MAX},
		'{ROW_CFG, 24'(REG_BAND), 24'd5, 1'b0, 16'sd0},
		'{ROW_TICK, 24'd0, 24'd0, 1'b1, SMP_MIN},
		'{ROW_CFG, 24'(REG_SPARE), 24'hFFFFFF, 1'b0, 16'sd0},
		'{ROW_TICK, 24'd0, 24'd0, 1'b1, SMP_MIN},
		'{ROW_CFG, 24'(REG_LEVEL), 24'd0, 1'b0, 16'sd0},
		'{ROW_TICK, 24'd0, 24'd0, 1'b1, 16'sd0},
		'{ROW_CFG, 24'(REG_BAND), 24'd3, 1'b0, 16'sd0},
		'{ROW_CFG, 24'(REG_LEVEL), 24'd32768, 1'b0, 16'sd0},
		'{ROW_CFG, 24'(REG_PHASE_STEP), 24'h002000, 1'b0, 16'sd0},
		'{ROW_CFG, 24'(REG_MOD_ENABLE), 24'd1, 1'b0, 16'sd0},
		'{ROW_TICK, 24'd0, 24'd0, 1'b1, SMP_MAX},
		'{ROW_CFG, 24'(REG_MOD_ENABLE), 24'd0, 1'b0, 16'sd0},
		'{ROW_TICK, 24'd0, 24'd0, 1'b1, 16'sd0},
		'{ROW_CFG, 24'(REG_PHASE_STEP), 24'hFFC000, 1'b0, 16'sd0},
		'{ROW_CFG, 24'(REG_MOD_ENABLE), 24'd1, 1'b0, 16'sd0},
		'{ROW_TICK, 24'd0, 24'd0, 1'b1, 16'sd0},
		'{ROW_TICK, 24'd0, 24'd0, 1'b0, 16'sd0},
		'{ROW_CFG, 24'(REG_WAVE_PRESENT), 24'd0, 1'b0, 16'sd0},
		'{ROW_TICK, 24'd0, 24'd0, 1'b1, 16'sd0}
	};

	wavetable_lfo_interpolating dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.table_address(table_address),
		.table_data(table_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample_out(sample_out)
	);

	always #5 clk = ~clk;

	// store address of the left (second = 0) or right neighbour at the current phase
	function automatic logic [ADDR_W-1:0] neighbour_addr(input bit second);
		longint idx;
		idx = (longint'(phase_acc) * TBL) >> PB;
		if (second)
			idx = (idx + 1 >= TBL) ? 0 : idx + 1;
		return ADDR_W'((longint'(band_r) % NB * TBL + idx) % STORE_DEPTH);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] lfo_tick_sample();
		longint frac, a, b, t, q, y;
		y = 0;
		if (present_r) begin
			frac = (longint'(phase_acc) * TBL) & PHASE_MASK;
			a = longint'($signed(wave_mem[neighbour_addr(1'b0)]));
			b = longint'($signed(wave_mem[neighbour_addr(1'b1)]));
			t = a * (longint'(1) << PB) + frac * (b - a);
			q = (t + (longint'(1) << (PB - 1))) >>> PB;
			y = (q * longint'(level_r) + 16384) >>> 15;
			if (y > SMP_MAX)
				y = SMP_MAX;
			if (y < SMP_MIN)
				y = SMP_MIN;
		end
		if (mod_r)
			phase_acc = phase_acc + step_r;
		return SAMPLE_W'(y);
	endfunction

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
		REG_PHASE_STEP: step_r = val[STEP_W-1:0];
		REG_LEVEL: level_r = val[LEVEL_W-1:0];
		REG_BAND: band_r = val[BAND_W-1:0];
		REG_MOD_ENABLE: mod_r = val[0];
		REG_WAVE_PRESENT: present_r = val[0];
		default: ;
		endcase
	endtask

	// drop valid, let every pending sample drain, then let the block settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic transfer(input logic act, input logic [ADDR_W-1:0] addr,
			input logic [SAMPLE_W-1:0] data, input bit typed,
			input logic signed [SAMPLE_W-1:0] typed_sample);
		logic signed [SAMPLE_W-1:0] s;
		int gap;
		in_valid <= 1'b1;
		action <= act;
		table_address <= addr;
		table_data <= data;
		do @(posedge clk); while (in_stall);
		if (act == ACT_WRITE) begin
			wave_mem[addr] = data;
			written[addr] = 1'b1;
		end else begin
			s = lfo_tick_sample();
			pending_samples.push_back(typed ? typed_sample : s);
		end
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			gap = gaps_on ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// a tick never reads a store entry that was not written first
	task automatic send_tick(input bit typed, input logic signed [SAMPLE_W-1:0] typed_sample);
		logic [ADDR_W-1:0] a0, a1;
		if (present_r) begin
			a0 = neighbour_addr(1'b0);
			a1 = neighbour_addr(1'b1);
			if (!written[a0])
				transfer(ACT_WRITE, a0, SAMPLE_W'($urandom), 1'b0, '0);
			if (!written[a1])
				transfer(ACT_WRITE, a1, SAMPLE_W'($urandom), 1'b0, '0);
		end
		transfer(ACT_TICK, ADDR_W'($urandom), SAMPLE_W'($urandom), typed, typed_sample);
	endtask

	initial begin : stimulus
		bit cfg_open;
		logic [ADDR_W-1:0] la;
		logic [SAMPLE_W-1:0] ld;
		logic [STEP_W-1:0] st;
		logic [LEVEL_W-1:0] lv;
		cfg_open = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				if (!cfg_open) begin
					wait_idle();
					cfg_open = 1'b1;
				end
				cfg_write(CFG_IDX_W'(dir_rows[i].sel), dir_rows[i].val);
			end else begin
				if (cfg_open) begin
					cfg_we <= 1'b0;
					cfg_open = 1'b0;
				end
				if (dir_rows[i].kind == ROW_LOAD)
					transfer(ACT_WRITE, ADDR_W'(dir_rows[i].sel), dir_rows[i].val[15:0],
						1'b0, '0);
				else
					send_tick(dir_rows[i].typed, dir_rows[i].want);
			end
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wait_idle();
			case ($urandom_range(0, 4))
			0: st = '0;
			1: st = '1;
			2: st = STEP_W'(1);
			3: st = STEP_W'($urandom_range(1, 65536));
			default: st = STEP_W'($urandom);
			endcase
			case ($urandom_range(0, 4))
			0: lv = '0;
			1: lv = 16'd32768;
			2: lv = '1;
			default: lv = LEVEL_W'($urandom);
			endcase
			cfg_write(REG_PHASE_STEP, st);
			cfg_write(REG_LEVEL, {8'($urandom), lv});
			cfg_write(REG_BAND, CFG_W'($urandom));
			cfg_write(REG_MOD_ENABLE, {23'($urandom), 1'($urandom_range(0, 3) != 0)});
			cfg_write(REG_WAVE_PRESENT, {23'($urandom), 1'($urandom_range(0, 4) != 0)});
			if ($urandom_range(0, 2) == 0)
				cfg_write(CFG_IDX_W'(REG_WAVE_PRESENT + 1 + $urandom_range(0, 2)),
					CFG_W'($urandom));
			cfg_we <= 1'b0;
			gaps_on = (ph % 3 != 1);
			if (ph == 2)
				hold_req = 1'b1;
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 9) < 3) begin
					if ($urandom_range(0, 1))
						la = ADDR_W'(int'(band_r) * TBL + $urandom_range(0, TBL - 1));
					else
						la = ADDR_W'($urandom);
					if ($urandom_range(0, 7) == 0)
						ld = $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
					else
						ld = SAMPLE_W'($urandom);
					transfer(ACT_WRITE, la, ld, 1'b0, '0);
				end else begin
					send_tick(1'b0, '0);
				end
			end
		end

		wait_idle();
		if (pending_samples.size() != 0) begin
			$error("sample_out: %0d samples never arrived", pending_samples.size());
			errors++;
		end
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	initial begin : receiver
		int mode, n;
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 3);
				n = $urandom_range(1, 16);
				repeat (n) begin
					case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= 1'($urandom_range(0, 1));
					2: out_stall <= 1'b1;
					default: out_stall <= ~out_stall;
					endcase
					@(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin : sample_check
		logic signed [SAMPLE_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_samples.size() == 0) begin
				$error("sample_out: transfer with nothing pending, got %0d", sample_out);
				errors++;
			end else begin
				want = pending_samples.pop_front();
				if (sample_out !== want) begin
					$error("sample_out: expected %0d, got %0d", want, sample_out);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end
endmodule

/* wavetable_lfo_interpolating.f */
+incdir+rtl/core
rtl/core/wtlfo_pkg.sv
rtl/core/wtlfo_ram.sv
rtl/core/wavetable_lfo_interpolating.sv
tb/tb_top.sv
